@@ rtl/idbd_pkg.sv @@
package idbd_pkg;

  // Field widths of one transfer.
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;

  // Whole-year day count and ordinal widths. Year 16383 still fits.
  localparam int unsigned OrdW   = 23;
  localparam int unsigned Q100W  = 8;
  localparam int unsigned DoyW   = 9;

  // Reciprocal of 100 scaled by 2**20. It is exact for every value below 43690.
  localparam int unsigned Recip100      = 10486;
  localparam int unsigned Recip100Shift = 20;

  // Limits of a valid date.
  localparam int unsigned DayMax   = 31;
  localparam int unsigned MonthMax = 12;
  localparam int unsigned YearMax  = 9999;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_BAD_END   = 2'd2,
    STATUS_NOT_AFTER = 2'd3
  } status_t;

  // Days in the year before the first of the given month (1..12).
  function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] days;
    unique case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

@@ rtl/inclusive_days_between_dates_top.sv @@
// Inclusive day count between two Gregorian dates.
//
// Each input transfer on the s_axis side carries a start date and an end date.
// Each one gives exactly one output transfer on the m_axis side with the number
// of days from start to end, both ends counted, and a status code. Any invalid
// field, or an end date that is not after the start, gives a count of zero.
//
// The block is a three-stage pipeline: the year split into centuries, then
// the day number of each date, then the difference and the output register.
// Output valid is the valid register of the third stage. One item is taken
// every cycle while the receiver keeps up.
//
// Each stage holds its item while the one after it is full and stalled, so a
// stall on m_axis_tready fills the empty stages first and then drops
// s_axis_tready; nothing is lost or repeated. Reset empties the pipeline.
module inclusive_days_between_dates_top import idbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
  // end_month[31:28], end_year[45:32], zero fill [47:46]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // day_count[21:0], status[23:22]
  output logic [23:0] m_axis_tdata
);

  logic [DayW-1:0]   start_day, end_day;
  logic [MonthW-1:0] start_month, end_month;
  logic [YearW-1:0]  start_year, end_year;

  assign start_day   = s_axis_tdata[4:0];
  assign start_month = s_axis_tdata[8:5];
  assign start_year  = s_axis_tdata[22:9];
  assign end_day     = s_axis_tdata[27:23];
  assign end_month   = s_axis_tdata[31:28];
  assign end_year    = s_axis_tdata[45:32];

  logic    valid1, valid2, valid3;
  logic    en1, en2, en3;
  status_t status1, status2, status3;
  status_t status_next;
  logic [CountW-1:0] count3;

  // Each stage moves when it is empty or the stage after it moves.
  assign en3           = !valid3 || m_axis_tready;
  assign en2           = !valid2 || en3;
  assign en1           = !valid1 || en2;
  assign s_axis_tready = en1;

  function automatic logic date_ok(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
                                   input logic [YearW-1:0] y);
    return (d != '0) && (DayW'(DayMax) >= d) && (m != '0) && (MonthW'(MonthMax) >= m)
           && (y != '0) && (YearW'(YearMax) >= y);
  endfunction

  // Status is settled in the first stage: start check, end check, then order.
  always_comb begin
    if (!date_ok(start_day, start_month, start_year)) begin
      status_next = STATUS_BAD_START;
    end else if (!date_ok(end_day, end_month, end_year)) begin
      status_next = STATUS_BAD_END;
    end else if ({end_year, end_month, end_day} > {start_year, start_month, start_day}) begin
      status_next = STATUS_OK;
    end else begin
      status_next = STATUS_NOT_AFTER;
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (en1) valid1 <= s_axis_tvalid;
      if (en2) valid2 <= valid1;
      if (en3) valid3 <= valid2;
    end
  end

  // Status travels along with the day numbers.
  always_ff @(posedge clk) begin
    if (en1) status1 <= status_next;
    if (en2) status2 <= status1;
    if (en3) status3 <= status2;
  end

  logic [OrdW-1:0] start_ord, end_ord;

  idbd_ordinal u_start_ord (
    .clk     (clk),
    .en1     (en1),
    .en2     (en2),
    .day     (start_day),
    .month   (start_month),
    .year    (start_year),
    .ordinal (start_ord)
  );

  idbd_ordinal u_end_ord (
    .clk     (clk),
    .en1     (en1),
    .en2     (en2),
    .day     (end_day),
    .month   (end_month),
    .year    (end_year),
    .ordinal (end_ord)
  );

  logic signed [OrdW+1:0] diff;

  // Stage 3: inclusive difference, zero on error and when an overlong start day overtakes the end.
  always_comb begin
    diff = $signed({2'b00, end_ord}) - $signed({2'b00, start_ord}) + (OrdW+2)'(1);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      if (status2 != STATUS_OK || diff <= 0) begin
        count3 <= '0;
      end else begin
        count3 <= diff[CountW-1:0];
      end
    end
  end

  assign m_axis_tvalid = valid3;
  assign m_axis_tdata  = {status3, count3};

endmodule

@@ rtl/idbd_ordinal.sv @@
// Two-stage day number of one date, counted from the first of January of year 1.
module idbd_ordinal import idbd_pkg::*; (
  input  logic              clk,
  input  logic              en1,
  input  logic              en2,
  input  logic [DayW-1:0]   day,
  input  logic [MonthW-1:0] month,
  input  logic [YearW-1:0]  year,
  output logic [OrdW-1:0]   ordinal
);

  localparam int unsigned ProdW = YearW + 14;

  logic [YearW-1:0]  p_s1;
  logic [Q100W-1:0]  q100_s1;
  logic [DayW-1:0]   day_s1;
  logic [MonthW-1:0] month_s1;

  logic [YearW-1:0]  p_next;
  logic [ProdW-1:0]  prod;

  // Stage 1: whole years before the date and their count of centuries.
  always_comb begin
    p_next = year - YearW'(1);
    prod   = ProdW'(p_next) * ProdW'(Recip100);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p_s1     <= p_next;
      q100_s1  <= prod[Recip100Shift +: Q100W];
      day_s1   <= day;
      month_s1 <= month;
    end
  end

  logic [YearW-1:0] rem100;
  logic             leap;
  logic [DoyW-1:0]  doy;
  logic [OrdW-1:0]  year_days;

  // Stage 2: leap rule from the remainders of the previous year, then the day number.
  always_comb begin
    rem100    = p_s1 - YearW'(q100_s1 * YearW'(100));
    // The year is a multiple of 4, of 100 or of 400 when the previous one leaves 3, 99 or 399 modulo 4, 100 or 400.
    leap      = (rem100 == YearW'(99)) ? (q100_s1[1:0] == 2'd3) : (p_s1[1:0] == 2'd3);
    doy       = month_start(month_s1) + DoyW'(day_s1)
              + DoyW'(leap && (month_s1 > MonthW'(2)));
    year_days = OrdW'(p_s1) * OrdW'(365) + OrdW'(p_s1[YearW-1:2])
              - OrdW'(q100_s1) + OrdW'(q100_s1[Q100W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ordinal <= year_days + OrdW'(doy);
    end
  end

endmodule
